### rtl/chd_pkg.sv
// Shared types and constants for the canonical Huffman decoder.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package chd_pkg;

  // Item kinds on the input channel
  typedef enum logic [1:0] {
    KIND_COUNT  = 2'd0,
    KIND_SYMBOL = 2'd1,
    KIND_BIT    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  // Bit engine phases
  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_EVAL = 1'b1
  } phase_t;

  localparam int ACC_W   = 32;  // code accumulator and first code
  localparam int COUNT_W = 9;   // stored per-length code count
  localparam int SYM_W   = 9;   // stored symbol value
  localparam int INDEX_W = 10;  // running first index, wraps
  localparam int SLOT_W  = 11;  // symbol slot sum, wide enough for 1024 slots
  localparam int IDX_W   = 9;   // load_index field
  localparam int BYTE_W  = 8;   // decoded byte

  localparam logic [SYM_W-1:0] END_SYMBOL = 9'd256;

  // Result request from the bit engine to the result stage
  typedef struct packed {
    logic valid;  // a result is due
    logic error;  // code ran past the maximum length
    logic blank;  // slot outside the table, symbol reads as zero
  } issue_t;

endpackage

`default_nettype wire

### rtl/chd_count_mem.sv
// Per-length code count memory with one valid bit per entry.
// Synchronous registered read; uses chd_pkg.
`default_nettype none

module chd_count_mem #(
  parameter int MAX_CODE_LEN = 32,
  parameter int LEN_W        = 5
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        wr_en,
  input  wire logic [LEN_W-1:0]            wr_addr,
  input  wire logic [chd_pkg::COUNT_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [LEN_W-1:0]            rd_addr,
  output logic      [chd_pkg::COUNT_W-1:0] rd_count
);

  logic [chd_pkg::COUNT_W-1:0] mem [MAX_CODE_LEN];
  logic [MAX_CODE_LEN-1:0]     valid;
  logic [chd_pkg::COUNT_W-1:0] rd_data;
  logic                        rd_valid;

  // Write count storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Track written entries; reset makes every count read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign rd_count = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

### rtl/chd_symbol_mem.sv
// Symbol table memory, sorted by code length then symbol value.
// One write port, one registered read port; uses chd_pkg.
`default_nettype none

module chd_symbol_mem #(
  parameter int SYMBOL_SLOTS = 512,
  parameter int SYM_AW       = 9
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [SYM_AW-1:0]         wr_addr,
  input  wire logic [chd_pkg::SYM_W-1:0] wr_data,
  input  wire logic                      rd_en,
  input  wire logic [SYM_AW-1:0]         rd_addr,
  output logic      [chd_pkg::SYM_W-1:0] rd_data
);

  logic [chd_pkg::SYM_W-1:0] mem [SYMBOL_SLOTS];

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/chd_result_stage.sv
// Result stage: holds a pending symbol read, formats it and drives the
// output register of the result channel. Uses chd_pkg.
`default_nettype none

module chd_result_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire chd_pkg::issue_t           issue,
  input  wire logic [chd_pkg::SYM_W-1:0] rd_data,
  output logic                           room,
  output logic                           result_valid,
  input  wire logic                      result_ready,
  output logic [chd_pkg::BYTE_W-1:0]     symbol,
  output logic                           end_marker,
  output logic                           code_error
);

  chd_pkg::issue_t            pend;
  logic                       move;
  logic [chd_pkg::SYM_W-1:0]  sym;
  logic                       is_end;

  // Pending item may advance when the output register is free or draining
  assign move = pend.valid && (!result_valid || result_ready);
  assign room = !pend.valid || !result_valid || result_ready;

  // Format the pending item
  always_comb begin
    sym    = (pend.error || pend.blank) ? '0 : rd_data;
    is_end = !pend.error && (sym == chd_pkg::END_SYMBOL);
  end

  // Hold pending request
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (issue.valid) begin
      pend <= issue;
    end else if (move) begin
      pend.valid <= 1'b0;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (move) begin
      symbol     <= is_end ? '0 : sym[chd_pkg::BYTE_W-1:0];
      end_marker <= is_end;
      code_error <= pend.error;
    end
  end

endmodule

`default_nettype wire

### rtl/canonical_huffman_decoder.sv
// Canonical Huffman decoder, one code bit per item, most significant first.
// A bit item is evaluated in the cycle after it is accepted; its result then
// goes to the pending register and on to the output register when it is free.
// No item is accepted while a bit is evaluated, since each bit's evaluation
// waits on the count memory read; load items need no evaluation phase.
// Reset: synchronous; clears count valid bits, decode registers and the result
// stage; symbol table contents are kept.
`default_nettype none

module canonical_huffman_decoder #(
  parameter int SYMBOL_SLOTS = 512,
  parameter int MAX_CODE_LEN = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  output logic                                  item_ready,
  input  wire logic [1:0]                       kind,
  input  wire logic [chd_pkg::IDX_W-1:0]        load_index,
  input  wire logic [chd_pkg::IDX_W-1:0]        load_value,
  input  wire logic                             code_bit,
  output logic                                  result_valid,
  input  wire logic                             result_ready,
  output logic [chd_pkg::BYTE_W-1:0]            symbol,
  output logic                                  end_marker,
  output logic                                  code_error
);

  localparam int LEN_W  = $clog2(MAX_CODE_LEN);
  localparam int SYM_AW = $clog2(SYMBOL_SLOTS);

  chd_pkg::phase_t state, state_next;

  logic                          accept;
  logic                          eval_en;
  logic                          room;
  logic                          bit_q;

  logic [LEN_W-1:0]              cls, cls_next;
  logic [chd_pkg::ACC_W-1:0]     fcode, fcode_next;
  logic [chd_pkg::ACC_W-1:0]     acc, acc_next;
  logic [chd_pkg::INDEX_W-1:0]   fidx, fidx_next;

  logic [chd_pkg::COUNT_W-1:0]   count;
  logic [chd_pkg::ACC_W-1:0]     acc_or;
  logic [chd_pkg::ACC_W-1:0]     fc_sh;
  logic [chd_pkg::ACC_W-1:0]     offset;
  logic                          hit;
  logic                          last;
  logic [chd_pkg::SLOT_W-1:0]    slot;
  logic [chd_pkg::SLOT_W-1:0]    idx_ext;
  logic                          blank;

  logic                          cnt_wr_en;
  logic                          sym_wr_en;
  logic                          sym_rd_en;
  logic [chd_pkg::SYM_W-1:0]     sym_rd_data;
  chd_pkg::issue_t               issue;

  assign accept  = item_valid && item_ready;
  assign idx_ext = {{(chd_pkg::SLOT_W - chd_pkg::IDX_W){1'b0}}, load_index};

  // Load writes
  assign cnt_wr_en = accept && (kind == chd_pkg::KIND_COUNT) &&
                     (load_index < chd_pkg::IDX_W'(MAX_CODE_LEN));
  assign sym_wr_en = accept && (kind == chd_pkg::KIND_SYMBOL) &&
                     (idx_ext < chd_pkg::SLOT_W'(SYMBOL_SLOTS));

  // Phase sequencing: fetch count on accept, evaluate next cycle
  always_comb begin
    state_next = state;
    case (state)
      chd_pkg::PH_IDLE: begin
        if (accept && (kind == chd_pkg::KIND_BIT)) begin
          state_next = chd_pkg::PH_EVAL;
        end
      end
      chd_pkg::PH_EVAL: begin
        state_next = chd_pkg::PH_IDLE;
      end
      default: begin
        state_next = chd_pkg::PH_IDLE;
      end
    endcase
  end

  // Phase outputs
  always_comb begin
    item_ready = 1'b0;
    eval_en    = 1'b0;
    case (state)
      chd_pkg::PH_IDLE: begin
        item_ready = room;
      end
      chd_pkg::PH_EVAL: begin
        eval_en = 1'b1;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chd_pkg::PH_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the code bit with the item
  always_ff @(posedge clk) begin
    if (accept) begin
      bit_q <= code_bit;
    end
  end

  // Count lookup for the current length
  chd_count_mem #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .LEN_W        (LEN_W)
  ) u_count_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cnt_wr_en),
    .wr_addr  (load_index[LEN_W-1:0]),
    .wr_data  (load_value),
    .rd_en    (accept),
    .rd_addr  (cls),
    .rd_count (count)
  );

  // Evaluate the extended code against the count of its length
  always_comb begin
    acc_or = acc | {{(chd_pkg::ACC_W - 1){1'b0}}, bit_q};
    fc_sh  = fcode << 1;
    offset = acc_or - fc_sh;
    hit    = offset < {{(chd_pkg::ACC_W - chd_pkg::COUNT_W){1'b0}}, count};
    last   = cls == LEN_W'(MAX_CODE_LEN - 1);
    slot   = {{(chd_pkg::SLOT_W - chd_pkg::COUNT_W){1'b0}}, offset[chd_pkg::COUNT_W-1:0]}
             + {{(chd_pkg::SLOT_W - chd_pkg::INDEX_W){1'b0}}, fidx};
    blank  = slot >= chd_pkg::SLOT_W'(SYMBOL_SLOTS);
  end

  // Decode register update and result request
  always_comb begin
    cls_next   = cls;
    fcode_next = fcode;
    acc_next   = acc;
    fidx_next  = fidx;
    issue      = '0;
    sym_rd_en  = 1'b0;
    if (eval_en) begin
      if (hit) begin
        issue.valid = 1'b1;
        issue.blank = blank;
        sym_rd_en   = !blank;
        cls_next    = '0;
        fcode_next  = '0;
        acc_next    = '0;
        fidx_next   = '0;
      end else if (last) begin
        issue.valid = 1'b1;
        issue.error = 1'b1;
        cls_next    = '0;
        fcode_next  = '0;
        acc_next    = '0;
        fidx_next   = '0;
      end else begin
        cls_next   = cls + 1'b1;
        fcode_next = fc_sh + {{(chd_pkg::ACC_W - chd_pkg::COUNT_W){1'b0}}, count};
        fidx_next  = fidx + {{(chd_pkg::INDEX_W - chd_pkg::COUNT_W){1'b0}}, count};
        acc_next   = acc_or << 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls   <= '0;
      fcode <= '0;
      acc   <= '0;
      fidx  <= '0;
    end else begin
      cls   <= cls_next;
      fcode <= fcode_next;
      acc   <= acc_next;
      fidx  <= fidx_next;
    end
  end

  // Symbol table
  chd_symbol_mem #(
    .SYMBOL_SLOTS (SYMBOL_SLOTS),
    .SYM_AW       (SYM_AW)
  ) u_symbol_mem (
    .clk     (clk),
    .wr_en   (sym_wr_en),
    .wr_addr (idx_ext[SYM_AW-1:0]),
    .wr_data (load_value),
    .rd_en   (sym_rd_en),
    .rd_addr (slot[SYM_AW-1:0]),
    .rd_data (sym_rd_data)
  );

  // Result formatting and output register
  chd_result_stage u_result_stage (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .rd_data      (sym_rd_data),
    .room         (room),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .symbol       (symbol),
    .end_marker   (end_marker),
    .code_error   (code_error)
  );

`ifndef SYNTHESIS
  a_bit_goes_to_eval: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == chd_pkg::KIND_BIT)) |=> (state == chd_pkg::PH_EVAL))
    else $error("bit item not evaluated in the following cycle");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    cls <= LEN_W'(MAX_CODE_LEN - 1))
    else $error("code length register past maximum");

  a_special_result_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (code_error || end_marker)) |->
      ((symbol == '0) && !(code_error && end_marker)))
    else $error("error or end marker result carries a symbol");

  a_issue_has_room: assert property (@(posedge clk) disable iff (rst)
    issue.valid |-> $past(item_ready))
    else $error("result requested without a free pending slot");
`endif

endmodule

`default_nettype wire
